>>> hw/rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants of the midpoint circle rasterizer: command
// codes, register indexes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int MaxDimDefault = 1024;
  localparam int QueueDepth    = 2;

  localparam int CoordW = 10;
  localparam int LenW   = 11;
  localparam int ColorW = 8;
  localparam int CfgW   = 11;
  localparam int ErrW   = 13;
  localparam int IncW   = 12;

  // command codes on the mode field
  localparam logic ModeStart = 1'b0;
  localparam logic ModeStep  = 1'b1;

  // configuration register indexes
  localparam logic CfgCanvasW = 1'b0;
  localparam logic CfgCanvasH = 1'b1;

  localparam logic [CfgW-1:0] CanvasReset = CfgW'(512);

  typedef enum logic [1:0] {
    JobReject,
    JobStart,
    JobStep
  } job_kind_e;

  // one classified item, ready to be expanded into results
  typedef struct packed {
    job_kind_e          kind;
    logic               fill;
    logic               fin;
    logic [CoordW-1:0]  cx;
    logic [CoordW-1:0]  cy;
    logic [CoordW-1:0]  a;
    logic [CoordW-1:0]  b;
    logic [ColorW-1:0]  color;
  } job_t;

endpackage

>>> hw/rtl/midpoint_circle_raster.sv
// ----------------------------------------------------------------------------
// midpoint_circle_raster
// Command-driven midpoint circle rasterizer: a front stage classifies and
// iterates, a job queue decouples it from a back stage that emits results.
// ----------------------------------------------------------------------------
// the first result of an item passes through the job queue and output register
// throughput: one result per cycle while out_ready_i allows; an outline step
//   gives 8 results, an outline start or fill step 4, a fill start or a
//   rejection 1; the front takes an item per cycle while the queue has room
// reset: idle, no circle in progress, canvas 512 by 512, no clearing pass
// ----------------------------------------------------------------------------
module midpoint_circle_raster import mcr_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [CoordW-1:0] center_x_i,
  input  logic [CoordW-1:0] center_y_i,
  input  logic [CoordW-1:0] radius_i,
  input  logic              fill_i,
  input  logic [ColorW-1:0] color_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] pix_x_o,
  output logic [CoordW-1:0] pix_y_o,
  output logic [LenW-1:0]   span_len_o,
  output logic [ColorW-1:0] pix_color_o,
  output logic              last_o,
  output logic              finished_o,
  output logic              rejected_o
);

  logic q_full, push, q_valid, pop;
  job_t push_job, head_job;

  mcr_front #(
    .MaxDim (MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .fill_i     (fill_i),
    .color_i    (color_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  mcr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (head_job),
    .pop_i   (pop)
  );

  mcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pix_x_o     (pix_x_o),
    .pix_y_o     (pix_y_o),
    .span_len_o  (span_len_o),
    .pix_color_o (pix_color_o),
    .last_o      (last_o),
    .finished_o  (finished_o),
    .rejected_o  (rejected_o)
  );

endmodule

>>> hw/rtl/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// Accepts commands, checks starts against the canvas, runs the midpoint
// iteration and hands one job per item to the queue.
// ----------------------------------------------------------------------------
module mcr_front import mcr_pkg::*; #(
  parameter int MaxDim = MaxDimDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [CoordW-1:0] center_x_i,
  input  logic [CoordW-1:0] center_y_i,
  input  logic [CoordW-1:0] radius_i,
  input  logic              fill_i,
  input  logic [ColorW-1:0] color_i,
  input  logic              q_full_i,
  output logic              push_o,
  output job_t              job_o
);

  localparam logic [13:0] DimLimit = 14'(MaxDim);

  logic [CfgW-1:0]   canvas_w_q, canvas_h_q;
  logic [CoordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [CoordW-1:0] a_q, a_d, b_q, b_d;
  logic signed [ErrW-1:0] err_q, err_d;
  logic [IncW-1:0]        inc_x_q, inc_x_d;
  logic signed [IncW-1:0] inc_y_q, inc_y_d;
  logic              fill_q, fill_d;
  logic [ColorW-1:0] color_q, color_d;
  logic              busy_q, busy_d;

  logic [13:0] w_ext, h_ext, w_cap, h_cap, x_ext, y_ext, r_ext;
  logic        bad_start, accept;

  logic                   err_ge0;
  logic [CoordW-1:0]      b_step, a_step;
  logic signed [IncW-1:0] inc_y_step;
  logic [IncW-1:0]        inc_x_step;
  logic signed [ErrW-1:0] err_mid, err_step;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= CanvasReset;
      canvas_h_q <= CanvasReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCanvasW: canvas_w_q <= cfg_data_i;
        CfgCanvasH: canvas_h_q <= cfg_data_i;
        default:    canvas_w_q <= canvas_w_q;
      endcase
    end
  end

  // start bounds check against the capped canvas
  assign w_ext = {3'b000, canvas_w_q};
  assign h_ext = {3'b000, canvas_h_q};
  assign w_cap = (w_ext > DimLimit) ? DimLimit : w_ext;
  assign h_cap = (h_ext > DimLimit) ? DimLimit : h_ext;
  assign x_ext = {4'b0000, center_x_i};
  assign y_ext = {4'b0000, center_y_i};
  assign r_ext = {4'b0000, radius_i};

  assign bad_start = (x_ext >= w_cap) || (y_ext >= h_cap) ||
                     ((x_ext + r_ext) >= w_cap) || ((y_ext + r_ext) >= h_cap) ||
                     (x_ext < r_ext) || (y_ext < r_ext);

  // one midpoint iteration
  assign err_ge0    = !err_q[ErrW-1];
  assign b_step     = err_ge0 ? (b_q - CoordW'(1)) : b_q;
  assign inc_y_step = err_ge0 ? (inc_y_q + IncW'(2)) : inc_y_q;
  assign err_mid    = err_ge0 ? (err_q + ErrW'(inc_y_step)) : err_q;
  assign a_step     = a_q + CoordW'(1);
  assign inc_x_step = inc_x_q + IncW'(2);
  assign err_step   = err_mid + $signed({1'b0, inc_x_step});

  always_comb begin
    cx_d    = cx_q;
    cy_d    = cy_q;
    a_d     = a_q;
    b_d     = b_q;
    err_d   = err_q;
    inc_x_d = inc_x_q;
    inc_y_d = inc_y_q;
    fill_d  = fill_q;
    color_d = color_q;
    busy_d  = busy_q;

    job_o       = '0;
    job_o.kind  = JobReject;

    unique case (mode_i)
      ModeStart: begin
        if (bad_start) begin
          busy_d = 1'b0;
        end else begin
          cx_d    = center_x_i;
          cy_d    = center_y_i;
          a_d     = '0;
          b_d     = radius_i;
          err_d   = ErrW'(1) - $signed({3'b000, radius_i});
          inc_x_d = IncW'(1);
          inc_y_d = IncW'(0) - $signed({1'b0, radius_i, 1'b0});
          fill_d  = fill_i;
          color_d = color_i;
          busy_d  = (radius_i != '0);

          job_o.kind  = JobStart;
          job_o.fill  = fill_i;
          job_o.fin   = (radius_i == '0);
          job_o.cx    = center_x_i;
          job_o.cy    = center_y_i;
          job_o.a     = '0;
          job_o.b     = radius_i;
          job_o.color = color_i;
        end
      end
      ModeStep: begin
        if (busy_q) begin
          a_d     = a_step;
          b_d     = b_step;
          err_d   = err_step;
          inc_x_d = inc_x_step;
          inc_y_d = inc_y_step;
          busy_d  = (a_step < b_step);

          job_o.kind  = JobStep;
          job_o.fill  = fill_q;
          job_o.fin   = !(a_step < b_step);
          job_o.cx    = cx_q;
          job_o.cy    = cy_q;
          job_o.a     = a_step;
          job_o.b     = b_step;
          job_o.color = color_q;
        end
      end
      default: begin
        busy_d = busy_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      err_q   <= '0;
      inc_x_q <= '0;
      inc_y_q <= '0;
      fill_q  <= 1'b0;
      color_q <= '0;
      busy_q  <= 1'b0;
    end else if (accept) begin
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      a_q     <= a_d;
      b_q     <= b_d;
      err_q   <= err_d;
      inc_x_q <= inc_x_d;
      inc_y_q <= inc_y_d;
      fill_q  <= fill_d;
      color_q <= color_d;
      busy_q  <= busy_d;
    end
  end

endmodule

>>> hw/rtl/mcr_queue.sv
// ----------------------------------------------------------------------------
// mcr_queue
// Short job queue between front and back, a circular buffer.
// ----------------------------------------------------------------------------
module mcr_queue import mcr_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  output logic valid_o,
  output job_t data_o,
  input  logic pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      unique case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> hw/rtl/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// Expands the job at the queue head into its points or spans, one result
// per cycle into the output register whenever it is empty or being read out.
// ----------------------------------------------------------------------------
module mcr_back import mcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] pix_x_o,
  output logic [CoordW-1:0] pix_y_o,
  output logic [LenW-1:0]   span_len_o,
  output logic [ColorW-1:0] pix_color_o,
  output logic              last_o,
  output logic              finished_o,
  output logic              rejected_o
);

  logic [2:0]        k_q;
  logic [2:0]        last_idx;
  logic              is_last, load;
  logic [CoordW-1:0] px, py;
  logic [LenW-1:0]   len;
  logic              rej;
  logic [CoordW-1:0] cx, cy, a, b;
  logic [LenW-1:0]   two_a, two_b;

  logic              out_valid_q;
  logic [CoordW-1:0] pix_x_q, pix_y_q;
  logic [LenW-1:0]   span_len_q;
  logic [ColorW-1:0] pix_color_q;
  logic              last_q, finished_q, rejected_q;

  assign cx    = job_i.cx;
  assign cy    = job_i.cy;
  assign a     = job_i.a;
  assign b     = job_i.b;
  assign two_a = {a, 1'b0};
  assign two_b = {b, 1'b0};

  always_comb begin
    px       = '0;
    py       = '0;
    len      = '0;
    rej      = 1'b0;
    last_idx = 3'd0;
    unique case (job_i.kind)
      JobStart: begin
        if (job_i.fill) begin
          px  = cx;
          py  = cy - b;
          len = two_b;
        end else begin
          last_idx = 3'd3;
          len      = LenW'(1);
          unique case (k_q[1:0])
            2'd0: begin px = cx;     py = cy + b; end
            2'd1: begin px = cx;     py = cy - b; end
            2'd2: begin px = cx + b; py = cy;     end
            2'd3: begin px = cx - b; py = cy;     end
            default: begin px = cx;  py = cy;     end
          endcase
        end
      end
      JobStep: begin
        if (job_i.fill) begin
          last_idx = 3'd3;
          unique case (k_q[1:0])
            2'd0: begin px = cx + a; py = cy - b; len = two_b; end
            2'd1: begin px = cx + b; py = cy - a; len = two_a; end
            2'd2: begin px = cx - a; py = cy - b; len = two_b; end
            2'd3: begin px = cx - b; py = cy - a; len = two_a; end
            default: begin px = cx;  py = cy;     len = '0;    end
          endcase
        end else begin
          last_idx = 3'd7;
          len      = LenW'(1);
          unique case (k_q)
            3'd0: begin px = cx + a; py = cy + b; end
            3'd1: begin px = cx - a; py = cy + b; end
            3'd2: begin px = cx + a; py = cy - b; end
            3'd3: begin px = cx - a; py = cy - b; end
            3'd4: begin px = cx + b; py = cy + a; end
            3'd5: begin px = cx - b; py = cy + a; end
            3'd6: begin px = cx + b; py = cy - a; end
            3'd7: begin px = cx - b; py = cy - a; end
            default: begin px = cx;  py = cy;     end
          endcase
        end
      end
      default: begin
        rej = 1'b1;
      end
    endcase
  end

  assign is_last = (k_q == last_idx);
  assign load    = job_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        k_q <= is_last ? 3'd0 : k_q + 3'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_x_q     <= px;
      pix_y_q     <= py;
      span_len_q  <= len;
      pix_color_q <= rej ? '0 : job_i.color;
      last_q      <= is_last;
      finished_q  <= rej ? 1'b0 : job_i.fin;
      rejected_q  <= rej;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pix_x_o     = pix_x_q;
  assign pix_y_o     = pix_y_q;
  assign span_len_o  = span_len_q;
  assign pix_color_o = pix_color_q;
  assign last_o      = last_q;
  assign finished_o  = finished_q;
  assign rejected_o  = rejected_q;

  // result counter never runs past the job's last result
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> k_q <= last_idx)
    else $error("result index beyond job");

  // counter is parked at zero between jobs
  a_k_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_valid_i |-> k_q == 3'd0)
    else $error("result index not cleared");

  // the job leaves the queue with its final result, and the counter restarts
  a_pop_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (k_q == 3'd0) && out_valid_q && last_q)
    else $error("job popped without final result");

  // a rejection is always a single, final result
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rejected_q) |-> (last_q && !finished_q))
    else $error("rejected result not final");

endmodule

>>> sim/mcr_checker.sv
// ----------------------------------------------------------------------------
// mcr_checker
// Watches the command and pixel channels of the circle rasterizer, keeps its
// own copy of the canvas size and the circle in progress, works out the
// pixels or spans each accepted command must produce and compares them in
// order with what comes out.
// ----------------------------------------------------------------------------
module mcr_checker import mcr_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              mode_i,
  input  logic [CoordW-1:0] center_x_i,
  input  logic [CoordW-1:0] center_y_i,
  input  logic [CoordW-1:0] radius_i,
  input  logic              fill_i,
  input  logic [ColorW-1:0] color_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CoordW-1:0] pix_x_i,
  input  logic [CoordW-1:0] pix_y_i,
  input  logic [LenW-1:0]   span_len_i,
  input  logic [ColorW-1:0] pix_color_i,
  input  logic              last_i,
  input  logic              finished_i,
  input  logic              rejected_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [LenW-1:0]   len;
    logic [ColorW-1:0] color;
    logic              last;
    logic              fin;
    logic              rej;
  } pixel_t;

  pixel_t pixel_q[$];
  int     fail_count = 0;
  int     pending = 0;

  logic [CfgW-1:0]   canvas_w;
  logic [CfgW-1:0]   canvas_h;
  int                ctr_x;
  int                ctr_y;
  int                minor;
  int                major;
  int                err;
  int                step_x;
  int                step_y;
  logic              fill_on;
  logic [ColorW-1:0] ink;
  logic              drawing;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic int eff_dim(logic [CfgW-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic void add_pixel(int x, int y, int len, logic last, logic fin);
    pixel_t p;
    p.x     = CoordW'(x);
    p.y     = CoordW'(y);
    p.len   = LenW'(len);
    p.color = ink;
    p.last  = last;
    p.fin   = fin;
    p.rej   = 1'b0;
    pixel_q.push_back(p);
  endfunction

  function automatic void add_reject();
    pixel_t p;
    p      = '0;
    p.last = 1'b1;
    p.rej  = 1'b1;
    pixel_q.push_back(p);
  endfunction

  function automatic void start_circle(int x0, int y0, int r, logic fill,
                                       logic [ColorW-1:0] color);
    int   w;
    int   h;
    logic fin;
    w = eff_dim(canvas_w);
    h = eff_dim(canvas_h);
    // any part off the canvas drops the circle in progress too
    if (x0 >= w || y0 >= h || x0 + r >= w || y0 + r >= h || x0 < r || y0 < r) begin
      drawing = 1'b0;
      add_reject();
      return;
    end
    ctr_x   = x0;
    ctr_y   = y0;
    minor   = 0;
    major   = r;
    err     = 1 - r;
    step_x  = 1;
    step_y  = -2 * r;
    fill_on = fill;
    ink     = color;
    fin     = (r == 0);
    drawing = !fin;
    if (fill_on) begin
      add_pixel(ctr_x, ctr_y - r, 2 * r, 1'b1, fin);
    end else begin
      add_pixel(ctr_x, ctr_y + r, 1, 1'b0, fin);
      add_pixel(ctr_x, ctr_y - r, 1, 1'b0, fin);
      add_pixel(ctr_x + r, ctr_y, 1, 1'b0, fin);
      add_pixel(ctr_x - r, ctr_y, 1, 1'b1, fin);
    end
  endfunction

  function automatic void step_circle();
    logic fin;
    int   a;
    int   b;
    if (!drawing) begin
      add_reject();
      return;
    end
    if (err >= 0) begin
      major  -= 1;
      step_y += 2;
      err    += step_y;
    end
    minor  += 1;
    step_x += 2;
    err    += step_x;
    fin     = !(minor < major);
    drawing = !fin;
    a = minor;
    b = major;
    if (fill_on) begin
      add_pixel(ctr_x + a, ctr_y - b, 2 * b, 1'b0, fin);
      add_pixel(ctr_x + b, ctr_y - a, 2 * a, 1'b0, fin);
      add_pixel(ctr_x - a, ctr_y - b, 2 * b, 1'b0, fin);
      add_pixel(ctr_x - b, ctr_y - a, 2 * a, 1'b1, fin);
    end else begin
      add_pixel(ctr_x + a, ctr_y + b, 1, 1'b0, fin);
      add_pixel(ctr_x - a, ctr_y + b, 1, 1'b0, fin);
      add_pixel(ctr_x + a, ctr_y - b, 1, 1'b0, fin);
      add_pixel(ctr_x - a, ctr_y - b, 1, 1'b0, fin);
      add_pixel(ctr_x + b, ctr_y + a, 1, 1'b0, fin);
      add_pixel(ctr_x - b, ctr_y + a, 1, 1'b0, fin);
      add_pixel(ctr_x + b, ctr_y - a, 1, 1'b0, fin);
      add_pixel(ctr_x - b, ctr_y - a, 1, 1'b1, fin);
    end
  endfunction

  function automatic void check_field(string name, logic [LenW-1:0] exp_v,
                                      logic [LenW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic void check_pixel();
    pixel_t p;
    if (pixel_q.size() == 0) begin
      $error("result with nothing pending: pix_x %0d pix_y %0d span_len %0d",
             pix_x_i, pix_y_i, span_len_i);
      fail_count++;
      return;
    end
    p = pixel_q.pop_front();
    check_field("pix_x", LenW'(p.x), LenW'(pix_x_i));
    check_field("pix_y", LenW'(p.y), LenW'(pix_y_i));
    check_field("span_len", p.len, span_len_i);
    check_field("pix_color", LenW'(p.color), LenW'(pix_color_i));
    check_field("last", LenW'(p.last), LenW'(last_i));
    check_field("finished", LenW'(p.fin), LenW'(finished_i));
    check_field("rejected", LenW'(p.rej), LenW'(rejected_i));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_q.delete();
      pending  = 0;
      canvas_w = CanvasReset;
      canvas_h = CanvasReset;
      ctr_x    = 0;
      ctr_y    = 0;
      minor    = 0;
      major    = 0;
      err      = 0;
      step_x   = 0;
      step_y   = 0;
      fill_on  = 1'b0;
      ink      = '0;
      drawing  = 1'b0;
    end else begin
      // results of this edge can only belong to items taken earlier
      if (out_valid_i && out_ready_i) begin
        check_pixel();
      end
      if (in_valid_i && in_ready_i) begin
        if (mode_i == ModeStart) begin
          start_circle(int'(center_x_i), int'(center_y_i), int'(radius_i), fill_i, color_i);
        end else begin
          step_circle();
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgCanvasW) begin
          canvas_w = cfg_data_i;
        end else begin
          canvas_h = cfg_data_i;
        end
      end
      pending = pixel_q.size();
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the circle rasterizer with directed corner cases and then random
// circle sequences over several canvas sizes, with random stalls on both
// channels; the checker beside the block predicts and compares the pixels.
// ----------------------------------------------------------------------------
module tb import mcr_pkg::*;;

  localparam int CycleLimit = 1000000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [CfgW-1:0]   cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              mode_i;
  logic [CoordW-1:0] center_x_i;
  logic [CoordW-1:0] center_y_i;
  logic [CoordW-1:0] radius_i;
  logic              fill_i;
  logic [ColorW-1:0] color_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CoordW-1:0] pix_x_o;
  logic [CoordW-1:0] pix_y_o;
  logic [LenW-1:0]   span_len_o;
  logic [ColorW-1:0] pix_color_o;
  logic              last_o;
  logic              finished_o;
  logic              rejected_o;
  int                fail_count;
  int                pending;

  int   items_sent = 0;
  int   eff_w = 512;
  int   eff_h = 512;
  logic no_gaps = 1'b0;

  midpoint_circle_raster dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .fill_i      (fill_i),
    .color_i     (color_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pix_x_o     (pix_x_o),
    .pix_y_o     (pix_y_o),
    .span_len_o  (span_len_o),
    .pix_color_o (pix_color_o),
    .last_o      (last_o),
    .finished_o  (finished_o),
    .rejected_o  (rejected_o)
  );

  mcr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .radius_i     (radius_i),
    .fill_i       (fill_i),
    .color_i      (color_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pix_x_i      (pix_x_o),
    .pix_y_i      (pix_y_o),
    .span_len_i   (span_len_o),
    .pix_color_i  (pix_color_o),
    .last_i       (last_o),
    .finished_i   (finished_o),
    .rejected_i   (rejected_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!no_gaps && $urandom_range(3, 0) == 0) begin
        out_ready_i <= 1'b0;
        repeat (gap_cycles()) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send(logic mode, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                      logic [CoordW-1:0] r, logic fill, logic [ColorW-1:0] color);
    int gap;
    gap = 0;
    if (!no_gaps && $urandom_range(1, 0) == 1) gap = gap_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    center_x_i <= x;
    center_y_i <= y;
    radius_i   <= r;
    fill_i     <= fill;
    color_i    <= color;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    items_sent++;
    @(negedge clk_i);
  endtask

  // step items ignore their payload, so it is kept random
  task automatic send_step();
    send(ModeStep, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
         1'($urandom), ColorW'($urandom));
  endtask

  task automatic draw_circle(logic fill, int x0, int y0, int r, logic [ColorW-1:0] color,
                             int nsteps);
    send(ModeStart, CoordW'(x0), CoordW'(y0), CoordW'(r), fill, color);
    repeat (nsteps) send_step();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_canvas(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    write_reg(CfgCanvasW, w);
    write_reg(CfgCanvasH, h);
    eff_w = (w > MaxDimDefault) ? MaxDimDefault : int'(w);
    eff_h = (h > MaxDimDefault) ? MaxDimDefault : int'(h);
  endtask

  task automatic random_sequence();
    int sel;
    int maxr;
    int r;
    int x0;
    int y0;
    int nsteps;
    sel  = $urandom_range(99, 0);
    maxr = ((eff_w < eff_h ? eff_w : eff_h) - 1) / 2;
    if (sel < 80 && eff_w > 0 && eff_h > 0) begin
      if ($urandom_range(9, 0) == 0) begin
        r = $urandom_range(maxr < 60 ? maxr : 60, 0);
      end else begin
        r = $urandom_range(maxr < 12 ? maxr : 12, 0);
      end
      x0 = $urandom_range(eff_w - 1 - r, r);
      y0 = $urandom_range(eff_h - 1 - r, r);
      // roughly where the octant closes, sometimes cut short
      nsteps = (r * 181) / 256 + $urandom_range(2, 0);
      if ($urandom_range(4, 0) == 0) nsteps = $urandom_range(nsteps, 0);
      draw_circle(1'($urandom), x0, y0, r, ColorW'($urandom), nsteps);
    end else if (sel < 90) begin
      // just past the right or bottom edge
      r = $urandom_range(20, 1);
      if ($urandom_range(1, 0) == 1) begin
        send(ModeStart, CoordW'(eff_w - r), CoordW'($urandom_range(1023, r)), CoordW'(r),
             1'($urandom), ColorW'($urandom));
      end else begin
        send(ModeStart, CoordW'($urandom_range(1023, r)), CoordW'(eff_h - r), CoordW'(r),
             1'($urandom), ColorW'($urandom));
      end
      send_step();
    end else begin
      send(1'($urandom), CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
           1'($urandom), ColorW'($urandom));
    end
  endtask

  task automatic run_phase(logic [CfgW-1:0] w, logic [CfgW-1:0] h, int n, logic quiet);
    int target;
    drain();
    set_canvas(w, h);
    no_gaps = quiet;
    target  = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(24, 0) == 0) drain();
      random_sequence();
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgCanvasW;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    mode_i     = ModeStart;
    center_x_i = '0;
    center_y_i = '0;
    radius_i   = '0;
    fill_i     = 1'b0;
    color_i    = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed cases on the 512 by 512 canvas left by reset
    send(ModeStep, '0, '0, '0, 1'b0, '0);
    draw_circle(1'b0, 0, 0, 0, 8'h00, 1);
    draw_circle(1'b1, 511, 511, 0, 8'hff, 0);
    send(ModeStart, 10'h3ff, 10'h3ff, 10'h3ff, 1'b1, 8'hff);
    send(ModeStart, 10'd5, 10'd100, 10'd10, 1'b0, 8'h5a);
    send(ModeStart, 10'd511, 10'd100, 10'd1, 1'b0, 8'ha5);
    draw_circle(1'b0, 100, 200, 3, 8'hff, 3);
    draw_circle(1'b1, 506, 5, 5, 8'h3c, 4);
    // a new start replaces the circle in progress
    draw_circle(1'b0, 256, 256, 20, 8'h81, 2);
    draw_circle(1'b1, 30, 40, 2, 8'h7e, 2);
    // a rejected start abandons the circle in progress
    draw_circle(1'b0, 50, 50, 10, 8'h11, 1);
    send(ModeStart, 10'd0, 10'd0, 10'd1, 1'b0, 8'h22);
    send_step();

    run_phase(11'd1024, 11'd1024, 60, 1'b1);
    run_phase(11'd1, 11'd1, 12, 1'b0);
    run_phase(11'd2047, 11'd300, 50, 1'b0);
    run_phase(11'd0, 11'd700, 10, 1'b0);
    run_phase(CfgW'($urandom_range(1100, 16)), CfgW'($urandom_range(1100, 16)), 60, 1'b0);
    drain();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mcr_pkg.sv
hw/rtl/mcr_front.sv
hw/rtl/mcr_queue.sv
hw/rtl/mcr_back.sv
hw/rtl/midpoint_circle_raster.sv
sim/mcr_checker.sv
sim/tb.sv
